// ----- src/ntc_pkg.sv -----
// Package for the NTC thermistor temperature filter.
// Holds the resistance table, clamp and scaling constants. No dependencies.
`timescale 1ns / 1ps
package ntc_pkg;

  localparam int TABLE_ENTRIES = 156;
  localparam int IDX_W         = 8;
  localparam int RES_W         = 30;
  localparam int TEMP_W        = 16;
  localparam int PULLUP_W      = 20;
  localparam int WEIGHT_W      = 17;
  localparam int T_MIN_C       = -30;

  localparam logic [0:0] REG_PULLUP = 1'b0;
  localparam logic [0:0] REG_WEIGHT = 1'b1;

  // calibration values in tenths of an ohm
  localparam logic [20:0] CAL_TENTHS [TABLE_ENTRIES] = '{
    21'd1792666, 21'd1684053, 21'd1582726, 21'd1488151, 21'd1399837, 21'd1317332,
    21'd1240216, 21'd1168107, 21'd1100648, 21'd1037512, 21'd978396, 21'd923020,
    21'd871124, 21'd822471, 21'd776837, 21'd734018, 21'd693823, 21'd656077,
    21'd620616, 21'd587288, 21'd555953, 21'd526480, 21'd498747, 21'd472643,
    21'd448062, 21'd424906, 21'd403086, 21'd382516, 21'd363117, 21'd344817,
    21'd327547, 21'd311243, 21'd295847, 21'd281301, 21'd267556, 21'd254562,
    21'd242274, 21'd230650, 21'd219650, 21'd209239, 21'd199380, 21'd190041,
    21'd181193, 21'd172807, 21'd164857, 21'd157317, 21'd150164, 21'd143376,
    21'd136933, 21'd130816, 21'd125005, 21'd119485, 21'd114239, 21'd109252,
    21'd104510, 21'd100000, 21'd95709, 21'd91626, 21'd87738, 21'd84037,
    21'd80512, 21'd77154, 21'd73953, 21'd70903, 21'd67995, 21'd65221,
    21'd62576, 21'd60051, 21'd57642, 21'd55342, 21'd53146, 21'd51049,
    21'd49045, 21'd47130, 21'd45300, 21'd43551, 21'd41878, 21'd40278,
    21'd38748, 21'd37283, 21'd35882, 21'd34540, 21'd33255, 21'd32025,
    21'd30846, 21'd29717, 21'd28635, 21'd27597, 21'd26603, 21'd25649,
    21'd24734, 21'd23856, 21'd23014, 21'd22206, 21'd21431, 21'd20686,
    21'd19970, 21'd19283, 21'd18623, 21'd17989, 21'd17380, 21'd16794,
    21'd16231, 21'd15689, 21'd15168, 21'd14667, 21'd14185, 21'd13722,
    21'd13275, 21'd12845, 21'd12431, 21'd12033, 21'd11649, 21'd11279,
    21'd10923, 21'd10580, 21'd10249, 21'd9930, 21'd9623, 21'd9326,
    21'd9040, 21'd8764, 21'd8498, 21'd8241, 21'd7994, 21'd7754,
    21'd7523, 21'd7300, 21'd7085, 21'd6877, 21'd6676, 21'd6482,
    21'd6295, 21'd6113, 21'd5938, 21'd5769, 21'd5605, 21'd5447,
    21'd5293, 21'd5145, 21'd5002, 21'd4863, 21'd4729, 21'd4599,
    21'd4474, 21'd4352, 21'd4234, 21'd4120, 21'd4009, 21'd3902,
    21'd3799, 21'd3698, 21'd3601, 21'd3506, 21'd3415, 21'd3326
  };

  // Q4 ohms, rounded half up
  function automatic logic [RES_W-1:0] res_entry(input logic [IDX_W-1:0] i);
    logic [RES_W+3:0] v;
    v = (34'(CAL_TENTHS[i]) * 34'd16 + 34'd5) / 34'd10;
    return v[RES_W-1:0];
  endfunction

endpackage

// ----- src/ntc_lane.sv -----
// One conversion lane: ADC code to temperature by division, table search and interpolation.
// Depends on ntc_pkg. Uses a shared restoring divider for both divisions, one bit a cycle.
`timescale 1ns / 1ps
module ntc_lane import ntc_pkg::*; #(
  parameter int ADC_BITS       = 12,
  parameter int TEMP_FRAC_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ADC_BITS-1:0]        code_in,
  input  logic [PULLUP_W-1:0]        pull_ohms,
  output logic                       done,
  output logic signed [TEMP_W-1:0]   temp
);

  localparam int NUM_W  = PULLUP_W + ADC_BITS + 4;
  localparam int QCNT_W = $clog2(NUM_W + 1);
  localparam logic [ADC_BITS-1:0] FS = {ADC_BITS{1'b1}};
  localparam int TW = TEMP_W + TEMP_FRAC_BITS + 2;
  localparam int T_COLD = T_MIN_C * (1 << TEMP_FRAC_BITS);
  localparam int T_HOT  = (T_MIN_C + TABLE_ENTRIES - 1) * (1 << TEMP_FRAC_BITS);
  localparam logic signed [TEMP_W-1:0] TEMP_COLD =
    (T_COLD < -32768) ? 16'sh8000 : TEMP_W'(T_COLD);
  localparam logic signed [TEMP_W-1:0] TEMP_HOT =
    (T_HOT > 32767) ? 16'sh7FFF : TEMP_W'(T_HOT);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_MUL  = 6'b000010, S_DIV1 = 6'b000100,
    S_SRCH = 6'b001000, S_DIV2 = 6'b010000, S_OUT  = 6'b100000
  } state_t;

  state_t state;
  logic [ADC_BITS-1:0] code;
  logic [NUM_W-1:0]    quo;
  logic [NUM_W-1:0]    rem;
  logic [NUM_W-1:0]    dvs;
  logic [QCNT_W-1:0]   cnt;
  logic [IDX_W-1:0]    lo, hi;
  logic [RES_W-1:0]    r;

  logic [NUM_W:0]      trial;
  logic [IDX_W-1:0]    mid;
  logic [RES_W-1:0]    t_lo, t_hi, t_mid;
  logic signed [TW-1:0] tval;
  logic [RES_W-1:0]    rtab [TABLE_ENTRIES];

  // Q4 table folded to constants, one entry per degree
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_tab
    localparam logic [RES_W-1:0] ENTRY = res_entry(IDX_W'(g));
    assign rtab[g] = ENTRY;
  end

  assign trial = {rem, quo[NUM_W-1]} - {1'b0, dvs};
  assign mid   = IDX_W'((9'(lo) + 9'(hi)) >> 1);
  assign t_lo  = rtab[lo];
  assign t_hi  = rtab[hi];
  assign t_mid = rtab[mid];
  assign tval  = (TW'(T_MIN_C) + $signed(TW'(lo))) * TW'(1 << TEMP_FRAC_BITS)
                 + $signed(TW'(quo));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            if (code_in == FS) code <= FS - 1'b1;
            else if (code_in == '0) code <= ADC_BITS'(1);
            else code <= code_in;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          quo   <= NUM_W'({pull_ohms, 4'b0000}) * NUM_W'(code);
          rem   <= '0;
          dvs   <= NUM_W'(FS - code);
          cnt   <= QCNT_W'(NUM_W);
          state <= S_DIV1;
        end
        S_DIV1: begin
          if (cnt == '0) begin
            r     <= quo[RES_W-1:0];
            lo    <= '0;
            hi    <= IDX_W'(TABLE_ENTRIES - 1);
            state <= S_SRCH;
            // a quotient at or above the coldest entry saturates cold, at or below the hottest saturates hot
            if (quo >= NUM_W'(res_entry('0))) begin
              temp  <= TEMP_COLD;
              state <= S_OUT;
            end else if (quo <= NUM_W'(res_entry(IDX_W'(TABLE_ENTRIES - 1)))) begin
              temp  <= TEMP_HOT;
              state <= S_OUT;
            end
          end else begin
            cnt <= cnt - 1'b1;
            if (!trial[NUM_W]) begin
              rem <= trial[NUM_W-1:0];
              quo <= {quo[NUM_W-2:0], 1'b1};
            end else begin
              rem <= {rem[NUM_W-2:0], quo[NUM_W-1]};
              quo <= {quo[NUM_W-2:0], 1'b0};
            end
          end
        end
        S_SRCH: begin
          if (hi - lo > IDX_W'(1)) begin
            if (r > t_mid) hi <= mid;
            else lo <= mid;
          end else begin
            quo   <= NUM_W'({t_lo - r, TEMP_FRAC_BITS'(0)});
            rem   <= '0;
            dvs   <= NUM_W'(t_lo - t_hi);
            cnt   <= QCNT_W'(NUM_W);
            state <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (cnt == '0) begin
            state <= S_OUT;
            if (tval > TW'(32767))
              temp <= 16'sh7FFF;
            else if (tval < -TW'(32768))
              temp <= 16'sh8000;
            else
              temp <= tval[TEMP_W-1:0];
          end else begin
            cnt <= cnt - 1'b1;
            if (!trial[NUM_W]) begin
              rem <= trial[NUM_W-1:0];
              quo <= {quo[NUM_W-2:0], 1'b1};
            end else begin
              rem <= {rem[NUM_W-2:0], quo[NUM_W-1]};
              quo <= {quo[NUM_W-2:0], 1'b0};
            end
          end
        end
        S_OUT: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/ntc_merge.sv -----
// Merging stage: seeds or blends both lane temperatures into the moving averages.
// Depends on ntc_pkg. Forms both products of a channel at once, steps through both channels.
`timescale 1ns / 1ps
module ntc_merge import ntc_pkg::*; #(
  parameter int TEMP_FRAC_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [TEMP_W-1:0]  t1,
  input  logic signed [TEMP_W-1:0]  t2,
  input  logic [WEIGHT_W-1:0]       weight,
  output logic                      done,
  output logic signed [TEMP_W-1:0]  f1,
  output logic signed [TEMP_W-1:0]  f2
);

  localparam int RESET_T = 25 * (1 << TEMP_FRAC_BITS);
  localparam logic signed [TEMP_W-1:0] RESET_TEMP =
    (RESET_T > 32767) ? 16'sh7FFF : TEMP_W'(RESET_T);

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001, M_MUL = 4'b0010, M_ADD = 4'b0100, M_NEXT = 4'b1000
  } mstate_t;

  mstate_t state;
  logic        ch;
  logic [1:0]  seeded;
  logic signed [35:0] pa, pb;
  logic [16:0] w;
  logic signed [TEMP_W-1:0] told, tnew;
  logic signed [36:0] acc;
  logic signed [20:0] q;
  logic signed [TEMP_W-1:0] qs;

  assign w    = (weight > 17'd65536) ? 17'd65536 : weight;
  assign told = ch ? f2 : f1;
  assign tnew = ch ? t2 : t1;
  assign acc  = 37'(pa) + 37'(pb) + 37'sd32768;
  assign q    = 21'(acc >>> 16);
  assign qs   = (q > 21'sd32767) ? 16'sh7FFF : (q < -21'sd32768) ? 16'sh8000 : q[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= M_IDLE;
      done   <= 1'b0;
      seeded <= '0;
      f1     <= RESET_TEMP;
      f2     <= RESET_TEMP;
      ch     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        M_IDLE: if (start) begin
          ch    <= 1'b0;
          state <= M_MUL;
        end
        M_MUL: begin
          pa    <= 36'(told) * $signed({1'b0, 18'd65536 - 18'(w)});
          pb    <= 36'(tnew) * $signed({1'b0, w});
          state <= M_ADD;
        end
        M_ADD: begin
          if (!seeded[ch]) begin
            if (ch) f2 <= tnew; else f1 <= tnew;
            seeded[ch] <= 1'b1;
          end else if (ch) f2 <= qs;
          else f1 <= qs;
          state <= M_NEXT;
        end
        M_NEXT: begin
          if (ch) begin
            done  <= 1'b1;
            state <= M_IDLE;
          end else begin
            ch    <= 1'b1;
            state <= M_MUL;
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

// ----- src/ntc_adc_to_temperature_filter.sv -----
// Channel        | dir | width | contents
// s_axis         | in  | 24    | tdata: sample_ch1 [11:0], sample_ch2 [23:12]
// m_axis         | out | 32    | tdata: temp_ch1 [15:0], temp_ch2 [31:16]
// cfg            | in  | 1+20  | cfg_index, cfg_data (pullup_ohms, smoothing_weight)
// Two lanes convert both channels at once; each lane runs two 36-step bit-serial divisions
// and an up to 8-step table search (search and second division are skipped when its
// quotient lies outside the table), then a merge steps through both channels.
// The next input transaction is taken the cycle after the result one.
// Synchronous reset restores 25 C, unseeded filters and default registers.
// Depends on ntc_pkg, ntc_lane and ntc_merge.
`timescale 1ns / 1ps
module ntc_adc_to_temperature_filter import ntc_pkg::*; #(
  parameter int ADC_BITS       = 12,
  parameter int TEMP_FRAC_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [2*ADC_BITS+((8-(2*ADC_BITS)%8)%8)-1:0] s_axis_tdata, // sample_ch1, sample_ch2
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [31:0]         m_axis_tdata, // temp_ch1, temp_ch2
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [19:0]         cfg_data
);

  logic [PULLUP_W-1:0] pullup_ohms;
  logic [WEIGHT_W-1:0] smoothing_weight;
  logic busy, start;
  logic d1, d2, got1, got2, mdone;
  logic signed [TEMP_W-1:0] t1, t2, f1, f2;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !busy;
  assign start         = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pullup_ohms      <= 20'd10000;
      smoothing_weight <= 17'd13107;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PULLUP: pullup_ohms      <= cfg_data;
        REG_WEIGHT: smoothing_weight <= cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  ntc_lane #(.ADC_BITS(ADC_BITS), .TEMP_FRAC_BITS(TEMP_FRAC_BITS)) u_lane1 (
    .clk, .rst, .start, .code_in(s_axis_tdata[ADC_BITS-1:0]), .pull_ohms(pullup_ohms),
    .done(d1), .temp(t1));
  ntc_lane #(.ADC_BITS(ADC_BITS), .TEMP_FRAC_BITS(TEMP_FRAC_BITS)) u_lane2 (
    .clk, .rst, .start, .code_in(s_axis_tdata[2*ADC_BITS-1:ADC_BITS]),
    .pull_ohms(pullup_ohms), .done(d2), .temp(t2));

  logic mstart;
  assign mstart = (got1 || d1) && (got2 || d2) && !(got1 && got2);

  ntc_merge #(.TEMP_FRAC_BITS(TEMP_FRAC_BITS)) u_merge (
    .clk, .rst, .start(mstart), .t1, .t2, .weight(smoothing_weight),
    .done(mdone), .f1, .f2);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; got1 <= 1'b0; got2 <= 1'b0; m_axis_tvalid <= 1'b0;
    end else begin
      if (start) busy <= 1'b1;
      if (mdone) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= {f2, f1};
        got1 <= 1'b0; got2 <= 1'b0;
      end else begin
        got1 <= got1 || d1;
        got2 <= got2 || d2;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
        busy <= 1'b0;
      end
    end
  end

endmodule
